FILE: hw/rtl/pai_pkg.sv
// shared types and codes for the positional array insert/delete block
package pai_pkg;

  // field widths
  localparam int CMD_W    = 3;
  localparam int POS_W    = 3;
  localparam int DATA_W   = 32;
  localparam int STATUS_W = 2;
  localparam int FILL_W   = 4;

  // most results one display command emits
  localparam int MAX_RES = 8;

  // command codes
  localparam logic [CMD_W-1:0] CMD_CLEAR   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_APPEND  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_INSERT  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_DELETE  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_MINMAX  = 3'd4;
  localparam logic [CMD_W-1:0] CMD_DISPLAY = 3'd5;

  // status codes
  localparam logic [STATUS_W-1:0] STAT_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_FULL   = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_EMPTY  = 2'd2;
  localparam logic [STATUS_W-1:0] STAT_BADPOS = 2'd3;

  // operation broadcast to every cell of the chain
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_DELETE,
    CELL_ROTATE
  } cell_op_t;

  // controller states
  typedef enum logic {
    FSM_IDLE,
    FSM_SCAN
  } fsm_state_t;

endpackage

FILE: hw/rtl/pai_cell.sv
// one storage cell of the element chain
module pai_cell #(
  parameter int IDX   = 0,
  parameter int CMP_W = 4
) (
  input  logic                          clk,
  input  pai_pkg::cell_op_t             op,
  input  logic [CMP_W-1:0]              pos,
  input  logic [CMP_W-1:0]              count,
  input  logic [pai_pkg::DATA_W-1:0]    value,
  input  logic [pai_pkg::DATA_W-1:0]    left,
  input  logic [pai_pkg::DATA_W-1:0]    right,
  input  logic [pai_pkg::DATA_W-1:0]    wrap,
  output logic [pai_pkg::DATA_W-1:0]    elem
);

  localparam logic [CMP_W:0] MY  = (CMP_W+1)'(IDX);
  localparam logic [CMP_W:0] MY1 = (CMP_W+1)'(IDX + 1);

  logic [pai_pkg::DATA_W-1:0] elem_next;
  logic [CMP_W:0]             pos_x;
  logic [CMP_W:0]             count_x;

  assign pos_x   = {1'b0, pos};
  assign count_x = {1'b0, count};

  // pick own value, a neighbor's, or the new element
  always_comb begin
    elem_next = elem;
    unique case (op)
      pai_pkg::CELL_INSERT: begin
        if (MY == pos_x) begin
          elem_next = value;
        end else if (MY > pos_x && MY <= count_x) begin
          elem_next = left;
        end
      end
      pai_pkg::CELL_DELETE: begin
        if (MY >= pos_x && MY1 < count_x) begin
          elem_next = right;
        end
      end
      pai_pkg::CELL_ROTATE: begin
        if (MY1 < count_x) begin
          elem_next = right;
        end else if (MY1 == count_x) begin
          elem_next = wrap;
        end
      end
      default: begin
        elem_next = elem;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    elem <= elem_next;
  end

endmodule

FILE: hw/rtl/positional_array_insert_delete.sv
// top level: command decode, scan sequencer, result register and the cell chain
//
// A bounded ordered array of signed 32-bit elements held in a chain of CAPACITY
// cells, one element per cell. Clear, append, insert and delete each return one
// result; insert and delete shift all later elements by one cell in the cycle
// the command is taken. Min/max query and display rotate the stored elements
// through cell 0 one step per cycle, so they occupy the block from acceptance
// through one rotation step per stored element (display emits the first eight
// of them, one per cycle, with last on the final one); a stalled result stalls
// the rotation. A new command is taken whenever the block is not rotating and
// the result register is empty or being drained in the same cycle.
module positional_array_insert_delete #(
  parameter int CAPACITY = 8
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic        [pai_pkg::CMD_W-1:0]       cmd,
  input  logic        [pai_pkg::POS_W-1:0]       position,
  input  logic signed [pai_pkg::DATA_W-1:0]      value,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic        [pai_pkg::STATUS_W-1:0]    status,
  output logic signed [pai_pkg::DATA_W-1:0]      item_value,
  output logic signed [pai_pkg::DATA_W-1:0]      minimum,
  output logic signed [pai_pkg::DATA_W-1:0]      maximum,
  output logic        [pai_pkg::FILL_W-1:0]      fill,
  output logic                                   last
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CMP_W = (CNT_W > pai_pkg::FILL_W) ? CNT_W : pai_pkg::FILL_W;
  localparam int RD_N  = (CAPACITY < pai_pkg::MAX_RES) ? CAPACITY : pai_pkg::MAX_RES;
  localparam logic [CMP_W-1:0] CAP_C  = CMP_W'(CAPACITY);
  localparam logic [CMP_W-1:0] MAXR_C = CMP_W'(pai_pkg::MAX_RES);

  // control registers
  pai_pkg::fsm_state_t state;
  pai_pkg::fsm_state_t state_next;
  logic [CNT_W-1:0]    count;
  logic [CNT_W-1:0]    count_next;
  logic [IDX_W-1:0]    scan_cnt;
  logic                scan_disp;
  logic [pai_pkg::DATA_W-1:0] mn_acc;
  logic [pai_pkg::DATA_W-1:0] mx_acc;

  // cell chain
  logic [pai_pkg::DATA_W-1:0] elems [CAPACITY];
  pai_pkg::cell_op_t          cell_op;
  logic [CMP_W-1:0]           cell_pos;

  // decode signals
  logic                       slot_free;
  logic                       accept;
  logic                       scan_start;
  logic                       step;
  logic                       scan_done;
  logic                       load;
  logic [CMP_W-1:0]           count_ext;
  logic [CMP_W-1:0]           pos_ext;
  logic [CMP_W-1:0]           scan_ext;
  logic [CMP_W-1:0]           shown;
  logic [pai_pkg::DATA_W-1:0] pos_elem;
  logic [pai_pkg::DATA_W-1:0] mn_new;
  logic [pai_pkg::DATA_W-1:0] mx_new;

  // result register inputs
  logic [pai_pkg::STATUS_W-1:0] status_d;
  logic [pai_pkg::DATA_W-1:0]   item_d;
  logic [pai_pkg::DATA_W-1:0]   min_d;
  logic [pai_pkg::DATA_W-1:0]   max_d;
  logic                         last_d;

  assign slot_free = !out_valid || out_ready;
  assign accept    = in_valid && in_ready;
  assign count_ext = CMP_W'(count);
  assign pos_ext   = CMP_W'(position);
  assign scan_ext  = CMP_W'(scan_cnt);
  assign shown     = (count_ext < MAXR_C) ? count_ext : MAXR_C;
  assign scan_done = step && (scan_ext == count_ext - CMP_W'(1));
  assign scan_start = accept && count != '0 &&
                      (cmd == pai_pkg::CMD_MINMAX || cmd == pai_pkg::CMD_DISPLAY);

  // element at the delete position, only the first eight cells are addressable
  always_comb begin
    pos_elem = '0;
    for (int j = 0; j < RD_N; j++) begin
      if (pos_ext == CMP_W'(j)) begin
        pos_elem = elems[j];
      end
    end
  end

  // running min/max with the element now in cell 0
  always_comb begin
    if (scan_cnt == '0) begin
      mn_new = elems[0];
      mx_new = elems[0];
    end else begin
      mn_new = ($signed(elems[0]) < $signed(mn_acc)) ? elems[0] : mn_acc;
      mx_new = ($signed(elems[0]) > $signed(mx_acc)) ? elems[0] : mx_acc;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      pai_pkg::FSM_IDLE: begin
        if (scan_start) begin
          state_next = pai_pkg::FSM_SCAN;
        end
      end
      pai_pkg::FSM_SCAN: begin
        if (scan_done) begin
          state_next = pai_pkg::FSM_IDLE;
        end
      end
      default: begin
        state_next = pai_pkg::FSM_IDLE;
      end
    endcase
  end

  // outputs of the sequencer: handshake, cell operation, result contents
  always_comb begin
    in_ready   = 1'b0;
    step       = 1'b0;
    load       = 1'b0;
    cell_op    = pai_pkg::CELL_HOLD;
    cell_pos   = count_ext;
    count_next = count;
    status_d   = pai_pkg::STAT_OK;
    item_d     = '0;
    min_d      = '0;
    max_d      = '0;
    last_d     = 1'b1;
    unique case (state)
      pai_pkg::FSM_IDLE: begin
        in_ready = slot_free;
        if (in_valid && slot_free) begin
          load = 1'b1;
          unique case (cmd) inside
            pai_pkg::CMD_CLEAR: begin
              count_next = '0;
            end
            pai_pkg::CMD_APPEND: begin
              if (count_ext >= CAP_C) begin
                status_d = pai_pkg::STAT_FULL;
              end else begin
                cell_op    = pai_pkg::CELL_INSERT;
                cell_pos   = count_ext;
                count_next = count + CNT_W'(1);
              end
            end
            pai_pkg::CMD_INSERT: begin
              if (count_ext >= CAP_C) begin
                status_d = pai_pkg::STAT_FULL;
              end else if (pos_ext > count_ext) begin
                status_d = pai_pkg::STAT_BADPOS;
              end else begin
                cell_op    = pai_pkg::CELL_INSERT;
                cell_pos   = pos_ext;
                count_next = count + CNT_W'(1);
              end
            end
            pai_pkg::CMD_DELETE: begin
              if (count == '0) begin
                status_d = pai_pkg::STAT_EMPTY;
              end else if (pos_ext >= count_ext) begin
                status_d = pai_pkg::STAT_BADPOS;
              end else begin
                cell_op    = pai_pkg::CELL_DELETE;
                cell_pos   = pos_ext;
                item_d     = pos_elem;
                count_next = count - CNT_W'(1);
              end
            end
            pai_pkg::CMD_MINMAX, pai_pkg::CMD_DISPLAY: begin
              if (count == '0) begin
                status_d = pai_pkg::STAT_EMPTY;
              end else begin
                load = 1'b0;
              end
            end
            default: begin
              status_d = pai_pkg::STAT_OK;
            end
          endcase
        end
      end
      pai_pkg::FSM_SCAN: begin
        step = slot_free;
        if (slot_free) begin
          cell_op = pai_pkg::CELL_ROTATE;
          if (scan_disp) begin
            load   = scan_ext < MAXR_C;
            item_d = elems[0];
            last_d = scan_ext == shown - CMP_W'(1);
          end else begin
            load  = scan_ext == count_ext - CMP_W'(1);
            min_d = mn_new;
            max_d = mx_new;
          end
        end
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= pai_pkg::FSM_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // scan counter, accumulators and result register
  always_ff @(posedge clk) begin
    if (scan_start) begin
      scan_cnt  <= '0;
      scan_disp <= cmd == pai_pkg::CMD_DISPLAY;
    end else if (step) begin
      scan_cnt <= scan_cnt + IDX_W'(1);
      mn_acc   <= mn_new;
      mx_acc   <= mx_new;
    end
    if (load) begin
      status     <= status_d;
      item_value <= item_d;
      minimum    <= min_d;
      maximum    <= max_d;
      fill       <= pai_pkg::FILL_W'(CMP_W'(count_next));
      last       <= last_d;
    end
  end

  // chain of cells, each sees its neighbors (cell 0 takes the new value on its left) and cell 0 for the wrap
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [pai_pkg::DATA_W-1:0] left_in;
    logic [pai_pkg::DATA_W-1:0] right_in;

    if (g == 0) begin : g_first
      assign left_in = value;
    end else begin : g_mid_l
      assign left_in = elems[g-1];
    end
    if (g == CAPACITY - 1) begin : g_end
      assign right_in = elems[0];
    end else begin : g_mid_r
      assign right_in = elems[g+1];
    end

    pai_cell #(
      .IDX   (g),
      .CMP_W (CMP_W)
    ) u_cell (
      .clk   (clk),
      .op    (cell_op),
      .pos   (cell_pos),
      .count (count_ext),
      .value (value),
      .left  (left_in),
      .right (right_in),
      .wrap  (elems[0]),
      .elem  (elems[g])
    );
  end

`ifndef ASSERT_OFF
  // count never passes the capacity
  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    count_ext <= CAP_C)
    else $error("element count above capacity");

  // no new command while elements are rotating
  a_no_accept_scan: assert property (@(posedge clk) disable iff (rst)
    state == pai_pkg::FSM_SCAN |-> !in_ready)
    else $error("input taken during scan");

  // scan index stays inside the stored elements
  a_scan_range: assert property (@(posedge clk) disable iff (rst)
    state == pai_pkg::FSM_SCAN |-> scan_ext < count_ext)
    else $error("scan index past count");

  // a result is only written into a free or draining slot
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    load |-> slot_free)
    else $error("result register overwritten");

  // a scan leaves the count unchanged
  a_scan_count: assert property (@(posedge clk) disable iff (rst)
    state == pai_pkg::FSM_SCAN |=> $stable(count))
    else $error("count changed during scan");
`endif

endmodule

FILE: sim/tb_positional_array_insert_delete.sv
// self-checking testbench for the positional array insert/delete block
module tb_positional_array_insert_delete;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CAP          = 8;
  localparam int RANDOM_ITEMS = 400;
  localparam int DRAIN_CYCLES = 40;
  localparam int MAX_PRINTS   = 40;

  typedef struct {
    logic        [pai_pkg::CMD_W-1:0]  cmd;
    logic        [pai_pkg::POS_W-1:0]  pos;
    logic signed [pai_pkg::DATA_W-1:0] val;
  } array_cmd_t;

  typedef struct {
    logic        [pai_pkg::STATUS_W-1:0] status;
    logic signed [pai_pkg::DATA_W-1:0]   item;
    logic signed [pai_pkg::DATA_W-1:0]   lo;
    logic signed [pai_pkg::DATA_W-1:0]   hi;
    logic        [pai_pkg::FILL_W-1:0]   fill;
    logic                                last;
  } array_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                                in_valid  = 1'b0;
  logic                                in_ready;
  logic        [pai_pkg::CMD_W-1:0]    cmd       = '0;
  logic        [pai_pkg::POS_W-1:0]    position  = '0;
  logic signed [pai_pkg::DATA_W-1:0]   value     = '0;
  logic                                out_valid;
  logic                                out_ready = 1'b0;
  logic        [pai_pkg::STATUS_W-1:0] status;
  logic signed [pai_pkg::DATA_W-1:0]   item_value;
  logic signed [pai_pkg::DATA_W-1:0]   minimum;
  logic signed [pai_pkg::DATA_W-1:0]   maximum;
  logic        [pai_pkg::FILL_W-1:0]   fill;
  logic                                last;

  positional_array_insert_delete #(.CAPACITY(CAP)) u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .cmd       (cmd),
    .position  (position),
    .value     (value),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .item_value(item_value),
    .minimum   (minimum),
    .maximum   (maximum),
    .fill      (fill),
    .last      (last)
  );

  // commands waiting to be driven and results waiting to arrive
  array_cmd_t    cmd_q[$];
  array_result_t exp_results[$];
  array_cmd_t    cur_cmd;
  array_result_t want;

  // shadow copy of the array contents
  logic signed [pai_pkg::DATA_W-1:0] model_elems[CAP];
  int                                model_count = 0;

  // element count as seen while building the stimulus
  int gen_count = 0;

  int err_count  = 0;
  int result_idx = 0;
  int in_gap     = 0;
  int out_stall  = 0;
  bit in_burst   = 1'b0;
  bit out_burst  = 1'b0;

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #10ms;
    $display("positional_array_insert_delete regression: fail");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    err_count++;
    if (err_count <= MAX_PRINTS) $display("%0t ns mismatch: %s", $realtime, msg);
  endtask

  task automatic push_result(input logic [pai_pkg::STATUS_W-1:0] st,
                             input logic signed [pai_pkg::DATA_W-1:0] it,
                             input logic signed [pai_pkg::DATA_W-1:0] lo,
                             input logic signed [pai_pkg::DATA_W-1:0] hi,
                             input logic lst);
    array_result_t r;
    r.status = st;
    r.item   = it;
    r.lo     = lo;
    r.hi     = hi;
    r.fill   = pai_pkg::FILL_W'(model_count);
    r.last   = lst;
    exp_results.push_back(r);
  endtask

  // expected results of one accepted command, updating the shadow array
  task automatic predict_array_op(input array_cmd_t c);
    logic signed [pai_pkg::DATA_W-1:0] gone;
    logic signed [pai_pkg::DATA_W-1:0] lo;
    logic signed [pai_pkg::DATA_W-1:0] hi;
    int i;
    int shown;
    case (c.cmd)
      pai_pkg::CMD_CLEAR: begin
        model_count = 0;
        push_result(pai_pkg::STAT_OK, 0, 0, 0, 1'b1);
      end
      pai_pkg::CMD_APPEND: begin
        if (model_count >= CAP) begin
          push_result(pai_pkg::STAT_FULL, 0, 0, 0, 1'b1);
        end else begin
          model_elems[model_count] = c.val;
          model_count++;
          push_result(pai_pkg::STAT_OK, 0, 0, 0, 1'b1);
        end
      end
      pai_pkg::CMD_INSERT: begin
        if (model_count >= CAP) begin
          push_result(pai_pkg::STAT_FULL, 0, 0, 0, 1'b1);
        end else if (int'(c.pos) > model_count) begin
          push_result(pai_pkg::STAT_BADPOS, 0, 0, 0, 1'b1);
        end else begin
          for (i = model_count; i > int'(c.pos); i--) model_elems[i] = model_elems[i-1];
          model_elems[c.pos] = c.val;
          model_count++;
          push_result(pai_pkg::STAT_OK, 0, 0, 0, 1'b1);
        end
      end
      pai_pkg::CMD_DELETE: begin
        if (model_count == 0) begin
          push_result(pai_pkg::STAT_EMPTY, 0, 0, 0, 1'b1);
        end else if (int'(c.pos) >= model_count) begin
          push_result(pai_pkg::STAT_BADPOS, 0, 0, 0, 1'b1);
        end else begin
          gone = model_elems[c.pos];
          for (i = c.pos; i + 1 < model_count; i++) model_elems[i] = model_elems[i+1];
          model_count--;
          push_result(pai_pkg::STAT_OK, gone, 0, 0, 1'b1);
        end
      end
      pai_pkg::CMD_MINMAX: begin
        if (model_count == 0) begin
          push_result(pai_pkg::STAT_EMPTY, 0, 0, 0, 1'b1);
        end else begin
          lo = model_elems[0];
          hi = model_elems[0];
          for (i = 1; i < model_count; i++) begin
            if (model_elems[i] < lo) lo = model_elems[i];
            if (model_elems[i] > hi) hi = model_elems[i];
          end
          push_result(pai_pkg::STAT_OK, 0, lo, hi, 1'b1);
        end
      end
      pai_pkg::CMD_DISPLAY: begin
        // only the first MAX_RES elements are shown, last on the final one
        if (model_count == 0) begin
          push_result(pai_pkg::STAT_EMPTY, 0, 0, 0, 1'b1);
        end else begin
          shown = (model_count < pai_pkg::MAX_RES) ? model_count : pai_pkg::MAX_RES;
          for (i = 0; i < shown; i++)
            push_result(pai_pkg::STAT_OK, model_elems[i], 0, 0, i == shown - 1);
        end
      end
      default: begin
        push_result(pai_pkg::STAT_OK, 0, 0, 0, 1'b1);
      end
    endcase
  endtask

  function automatic int pick_idle();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 92) return $urandom_range(4, 10);
    return $urandom_range(11, 40);
  endfunction

  // random element value with extra weight on extremes and near-equal values
  function automatic logic signed [pai_pkg::DATA_W-1:0] pick_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom;
    if (r < 85) begin
      case ($urandom_range(0, 3))
        0: return 32'sh8000_0000;
        1: return 32'sh7fff_ffff;
        2: return 32'sh0;
        default: return -32'sd1;
      endcase
    end
    return $signed($urandom_range(0, 8)) - 4;
  endfunction

  // queue one command and track the count it leaves behind
  task automatic add_cmd(input logic [pai_pkg::CMD_W-1:0] c, input int p,
                         input logic signed [pai_pkg::DATA_W-1:0] v);
    array_cmd_t a;
    a.cmd = c;
    a.pos = pai_pkg::POS_W'(p);
    a.val = v;
    cmd_q.push_back(a);
    case (c)
      pai_pkg::CMD_CLEAR:  gen_count = 0;
      pai_pkg::CMD_APPEND: if (gen_count < CAP) gen_count++;
      pai_pkg::CMD_INSERT: if (gen_count < CAP && p <= gen_count) gen_count++;
      pai_pkg::CMD_DELETE: if (gen_count > 0 && p < gen_count) gen_count--;
      default: ;
    endcase
  endtask

  // driver: one command per transfer, random gaps between them
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) predict_array_op(cur_cmd);
      if (!in_valid || in_ready) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (cmd_q.size() > 0) begin
          cur_cmd = cmd_q.pop_front();
          cmd      <= cur_cmd.cmd;
          position <= cur_cmd.pos;
          value    <= cur_cmd.val;
          in_valid <= 1'b1;
          if ($urandom_range(0, 39) == 0) in_burst = !in_burst;
          in_gap = (in_burst || $urandom_range(0, 1)) ? 0 : pick_idle();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: check each result transfer, stall the output at random
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (exp_results.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with nothing expected", result_idx));
        end else begin
          want = exp_results.pop_front();
          if (status !== want.status)
            report_mismatch($sformatf("result %0d status %0d, expected %0d",
                                      result_idx, status, want.status));
          if (item_value !== want.item)
            report_mismatch($sformatf("result %0d item_value %0d, expected %0d",
                                      result_idx, item_value, want.item));
          if (minimum !== want.lo)
            report_mismatch($sformatf("result %0d minimum %0d, expected %0d",
                                      result_idx, minimum, want.lo));
          if (maximum !== want.hi)
            report_mismatch($sformatf("result %0d maximum %0d, expected %0d",
                                      result_idx, maximum, want.hi));
          if (fill !== want.fill)
            report_mismatch($sformatf("result %0d fill %0d, expected %0d",
                                      result_idx, fill, want.fill));
          if (last !== want.last)
            report_mismatch($sformatf("result %0d last %0b, expected %0b",
                                      result_idx, last, want.last));
        end
        result_idx++;
      end
      if ($urandom_range(0, 199) == 0) out_burst = !out_burst;
      if (out_stall > 0) begin
        out_stall--;
        out_ready <= 1'b0;
      end else if (!out_burst && $urandom_range(0, 99) < 15) begin
        out_stall = pick_idle() - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    int counted;
    int r;
    int p;

    // directed: empty cases, extremes, shifts at both ends, full cases
    add_cmd(pai_pkg::CMD_DISPLAY, 0, 0);
    add_cmd(pai_pkg::CMD_MINMAX, 0, 0);
    add_cmd(pai_pkg::CMD_DELETE, 0, 0);
    add_cmd(pai_pkg::CMD_INSERT, 3, 32'sd5);
    add_cmd(pai_pkg::CMD_INSERT, 0, 32'sh8000_0000);
    add_cmd(pai_pkg::CMD_APPEND, 7, 32'sh7fff_ffff);
    add_cmd(pai_pkg::CMD_APPEND, 0, 32'sd0);
    add_cmd(pai_pkg::CMD_APPEND, 0, -32'sd1);
    add_cmd(pai_pkg::CMD_INSERT, 4, 32'sh1234_5678);
    add_cmd(pai_pkg::CMD_INSERT, 1, 32'sh5555_5555);
    add_cmd(pai_pkg::CMD_DELETE, 7, 0);
    add_cmd(pai_pkg::CMD_MINMAX, 0, 0);
    add_cmd(pai_pkg::CMD_DISPLAY, 0, 0);
    add_cmd(pai_pkg::CMD_APPEND, 0, 32'shaaaa_aaaa);
    add_cmd(pai_pkg::CMD_APPEND, 0, 32'sd42);
    add_cmd(pai_pkg::CMD_APPEND, 0, -32'sd42);
    add_cmd(pai_pkg::CMD_APPEND, 0, 32'sd1);
    add_cmd(pai_pkg::CMD_INSERT, 0, 32'sd1);
    add_cmd(pai_pkg::CMD_DISPLAY, 0, 0);
    add_cmd(pai_pkg::CMD_DELETE, 7, 0);
    add_cmd(pai_pkg::CMD_DELETE, 0, 0);
    add_cmd(pai_pkg::CMD_INSERT, 7, 32'sd99);
    add_cmd(3'd6, 5, 32'sh7fff_ffff);
    add_cmd(3'd7, 2, 32'sh8000_0000);
    add_cmd(pai_pkg::CMD_CLEAR, 0, 0);
    add_cmd(pai_pkg::CMD_DISPLAY, 0, 0);

    // random: mostly legal positions so the array fills and drains
    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 4) begin
        add_cmd(pai_pkg::CMD_CLEAR, $urandom_range(0, 7), $urandom);
      end else if (r < 22) begin
        add_cmd(pai_pkg::CMD_APPEND, $urandom_range(0, 7), pick_value());
      end else if (r < 40) begin
        if (gen_count < CAP && $urandom_range(0, 9) < 8) p = $urandom_range(0, gen_count);
        else p = $urandom_range(0, 7);
        add_cmd(pai_pkg::CMD_INSERT, p, pick_value());
      end else if (r < 68) begin
        if (gen_count > 0 && $urandom_range(0, 9) < 8) p = $urandom_range(0, gen_count - 1);
        else p = $urandom_range(0, 7);
        add_cmd(pai_pkg::CMD_DELETE, p, $urandom);
      end else if (r < 82) begin
        add_cmd(pai_pkg::CMD_MINMAX, $urandom_range(0, 7), $urandom);
      end else if (r < 96) begin
        add_cmd(pai_pkg::CMD_DISPLAY, $urandom_range(0, 7), $urandom);
      end else begin
        add_cmd(pai_pkg::CMD_W'($urandom_range(6, 7)), $urandom_range(0, 7), $urandom);
        counted--;
      end
      counted++;
    end

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // wait for every command to transfer, then for every result
    do @(negedge clk); while (cmd_q.size() > 0 || in_valid);
    while (exp_results.size() > 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (err_count == 0) begin
      $display("positional_array_insert_delete regression: pass");
    end else begin
      $display("positional_array_insert_delete regression: fail");
    end
    $finish;
  end

endmodule
